>>> rtl/sine_table_interpolator_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef SINE_TABLE_INTERPOLATOR_DEFINES_SVH
`define SINE_TABLE_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define STI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sine table interpolator: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define STI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sine table interpolator: assertion failed");

`else

`define STI_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define STI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/sti_pkg.sv
`default_nettype none

package sti_pkg;

    localparam int STI_TABLE_ENTRIES   = 360;
    localparam int STI_ANGLE_FRAC_BITS = 8;
    localparam int STI_SINE_FRAC_BITS  = 14;

    localparam int STI_ANGLE_W = 17;
    localparam int STI_SINE_W  = 16;

    localparam int STI_SINE_MAX = 32767;
    localparam int STI_SINE_MIN = -32768;

    localparam longint unsigned STI_PI_Q60  = 64'h3243F6A8885A308D;
    localparam longint unsigned STI_ONE_Q30 = 64'd1 << 30;

    function automatic longint unsigned sti_rnd30(longint unsigned p);
        return (p + (64'd1 << 29)) >> 30;
    endfunction

    // Sine of entry i (taken modulo one turn) with sfb fraction bits, from the
    // folded four-term odd Taylor polynomial in Q30 fixed point.
    function automatic longint sti_entry(int unsigned i, int unsigned sfb);
        int               d;
        bit               neg;
        longint unsigned  k;
        longint unsigned  a;
        longint unsigned  a2;
        longint unsigned  t;
        longint unsigned  p;
        int unsigned      sh;
        d   = int'(i % 360);
        neg = 1'b0;
        if (d >= 90 && d < 270) begin
            d   = d - 180;
            neg = 1'b1;
        end else if (d >= 270) begin
            d = d - 360;
        end
        if (d < 0) begin
            d   = -d;
            neg = !neg;
        end
        k  = STI_PI_Q60 / 180;
        a  = sti_rnd30(longint'(d) * k);
        a2 = sti_rnd30(a * a);
        t  = STI_ONE_Q30 - ((a2 + 21) / 42);
        t  = STI_ONE_Q30 - ((sti_rnd30(a2 * t) + 10) / 20);
        t  = STI_ONE_Q30 - ((sti_rnd30(a2 * t) + 3) / 6);
        p  = sti_rnd30(a * t);
        sh = 30 - sfb;
        if (sh > 0) begin
            p = (p + (64'd1 << (sh - 1))) >> sh;
        end
        return neg ? -longint'(p) : longint'(p);
    endfunction

endpackage

`default_nettype wire

>>> rtl/sti_rom.sv
`default_nettype none

module sti_rom
    import sti_pkg::*;
#(
    parameter int TABLE_ENTRIES   = STI_TABLE_ENTRIES,
    parameter int SINE_FRAC_BITS  = STI_SINE_FRAC_BITS,
    parameter int ADDR_W          = $clog2(TABLE_ENTRIES),
    parameter int DATA_W          = SINE_FRAC_BITS + 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [ADDR_W-1:0]        i_addr_a,
    input  wire logic [ADDR_W-1:0]        i_addr_b,
    output logic signed [DATA_W-1:0]      o_data_a,
    output logic signed [DATA_W-1:0]      o_data_b
);

    typedef logic signed [DATA_W-1:0] t_rom [TABLE_ENTRIES];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            rom[i] = DATA_W'(sti_entry(i, SINE_FRAC_BITS));
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic signed [DATA_W-1:0] r_data_a;
    logic signed [DATA_W-1:0] r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= ROM[i_addr_a];
            r_data_b <= ROM[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

`default_nettype wire

>>> rtl/sti_lerp.sv
`default_nettype none

module sti_lerp
    import sti_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = STI_ANGLE_FRAC_BITS,
    parameter int DATA_W          = STI_SINE_FRAC_BITS + 2,
    parameter int FRAC_W          = (ANGLE_FRAC_BITS == 0) ? 1 : ANGLE_FRAC_BITS
) (
    input  wire logic                      i_zero,
    input  wire logic [FRAC_W-1:0]         i_frac,
    input  wire logic signed [DATA_W-1:0]  i_lo,
    input  wire logic signed [DATA_W-1:0]  i_hi,
    output logic signed [STI_SINE_W-1:0]   o_sine
);

    localparam int PW = DATA_W + FRAC_W + 2;
    localparam int RW = (PW + 1 > STI_SINE_W + 1) ? PW + 1 : STI_SINE_W + 1;
    localparam logic [PW-1:0] HALF = PW'((longint'(1) << ANGLE_FRAC_BITS) >> 1);
    localparam logic signed [RW-1:0] SAT_HI = RW'(STI_SINE_MAX);
    localparam logic signed [RW-1:0] SAT_LO = RW'(STI_SINE_MIN);

    logic signed [DATA_W:0]   diff;
    logic signed [FRAC_W:0]   frac_s;
    logic signed [PW-1:0]     prod;
    logic signed [PW-1:0]     num;
    logic [PW-1:0]            mag;
    logic [PW-1:0]            rnd;
    logic signed [RW-1:0]     rnd_s;
    logic signed [RW-1:0]     res;

    // The blend lo*(1-f) + hi*f is formed as lo*2^F + (hi-lo)*f.
    always_comb begin
        diff   = (DATA_W+1)'(i_hi) - (DATA_W+1)'(i_lo);
        frac_s = signed'({1'b0, i_frac});
        prod   = PW'(diff) * PW'(frac_s);
        num    = (PW'(i_lo) <<< ANGLE_FRAC_BITS) + prod;
        mag    = num[PW-1] ? PW'(-num) : PW'(num);
        rnd    = (mag + HALF) >> ANGLE_FRAC_BITS;
        rnd_s  = signed'(RW'(rnd));
        res    = num[PW-1] ? -rnd_s : rnd_s;
        if (i_zero) begin
            o_sine = '0;
        end else if (res > SAT_HI) begin
            o_sine = STI_SINE_W'(STI_SINE_MAX);
        end else if (res < SAT_LO) begin
            o_sine = STI_SINE_W'(STI_SINE_MIN);
        end else begin
            o_sine = res[STI_SINE_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sine_table_interpolator.sv
// Channel   Direction  Valid     Stall     Payload
// input     in         i_valid   o_stall   i_angle_deg    (17 bits, unsigned)
// output    out        o_valid   i_stall   o_sine_value   (16 bits, signed)
//
// One transaction is accepted every cycle while o_stall is low. The first stage is the
// registered read of both table entries, the second the interpolation multiply
// into the result register.
// Reset is synchronous and active low; it clears both stage valid bits only.
// A stalled result holds; input is still taken while the middle stage is empty.
`default_nettype none

`include "sine_table_interpolator_defines.svh"

module sine_table_interpolator
    import sti_pkg::*;
#(
    parameter int TABLE_ENTRIES   = STI_TABLE_ENTRIES,
    parameter int ANGLE_FRAC_BITS = STI_ANGLE_FRAC_BITS,
    parameter int SINE_FRAC_BITS  = STI_SINE_FRAC_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [STI_ANGLE_W-1:0]     i_angle_deg,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [STI_SINE_W-1:0]    o_sine_value
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int DATA_W = SINE_FRAC_BITS + 2;
    localparam int FRAC_W = (ANGLE_FRAC_BITS == 0) ? 1 : ANGLE_FRAC_BITS;
    localparam longint unsigned LIMIT = longint'(TABLE_ENTRIES) << ANGLE_FRAC_BITS;
    localparam logic [STI_ANGLE_W-1:0] FRAC_MASK =
        STI_ANGLE_W'((longint'(1) << ANGLE_FRAC_BITS) - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

    logic                        out_en;
    logic                        s1_en;
    logic                        in_zero;
    logic [STI_ANGLE_W-1:0]      idx_full;
    logic [ADDR_W-1:0]           idx;
    logic [ADDR_W-1:0]           idx_next;
    logic [FRAC_W-1:0]           in_frac;
    logic signed [DATA_W-1:0]    rom_lo;
    logic signed [DATA_W-1:0]    rom_hi;
    logic signed [STI_SINE_W-1:0] lerp_sine;

    logic                        r_s1_valid;
    logic                        n_s1_valid;
    logic                        r_s1_zero;
    logic                        n_s1_zero;
    logic [FRAC_W-1:0]           r_s1_frac;
    logic [FRAC_W-1:0]           n_s1_frac;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic signed [STI_SINE_W-1:0] r_sine;
    logic signed [STI_SINE_W-1:0] n_sine;

    assign out_en  = !r_out_valid || !i_stall;
    assign s1_en   = !r_s1_valid || out_en;
    assign o_stall = !s1_en;

    always_comb begin
        in_zero  = (i_angle_deg == '0) || (64'(i_angle_deg) >= LIMIT);
        idx_full = i_angle_deg >> ANGLE_FRAC_BITS;
        idx      = idx_full[ADDR_W-1:0];
        idx_next = (idx == LAST_ADDR) ? '0 : idx + 1'b1;
        in_frac  = FRAC_W'(i_angle_deg & FRAC_MASK);
    end

    sti_rom #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .SINE_FRAC_BITS (SINE_FRAC_BITS),
        .ADDR_W         (ADDR_W),
        .DATA_W         (DATA_W)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (s1_en),
        .i_addr_a (idx),
        .i_addr_b (idx_next),
        .o_data_a (rom_lo),
        .o_data_b (rom_hi)
    );

    sti_lerp #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .DATA_W          (DATA_W),
        .FRAC_W          (FRAC_W)
    ) u_lerp (
        .i_zero (r_s1_zero),
        .i_frac (r_s1_frac),
        .i_lo   (rom_lo),
        .i_hi   (rom_hi),
        .o_sine (lerp_sine)
    );

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1_zero   = r_s1_zero;
        n_s1_frac   = r_s1_frac;
        n_out_valid = r_out_valid;
        n_sine      = r_sine;
        if (s1_en) begin
            n_s1_valid = i_valid;
            n_s1_zero  = in_zero;
            n_s1_frac  = in_frac;
        end
        if (out_en) begin
            n_out_valid = r_s1_valid;
            if (r_s1_valid) begin
                n_sine = lerp_sine;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
        r_s1_zero <= n_s1_zero;
        r_s1_frac <= n_s1_frac;
        r_sine    <= n_sine;
    end

    assign o_valid      = r_out_valid;
    assign o_sine_value = r_sine;

    `STI_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, r_s1_valid && r_out_valid && i_stall)
    `STI_ASSERT_NEXT(a_mid_stage_holds, i_clk, i_rst_n, r_s1_valid && !out_en, r_s1_valid && $stable(r_s1_frac) && $stable(r_s1_zero))
    `STI_ASSERT_NEXT(a_zero_angle_gives_zero, i_clk, i_rst_n, r_s1_valid && out_en && r_s1_zero, o_valid && (o_sine_value == '0))
    `STI_ASSERT_NEXT(a_result_from_mid_stage, i_clk, i_rst_n, out_en && r_s1_valid, o_valid)

endmodule

`default_nettype wire
